[design/dflr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and character constants for the decimal float literal recognizer.
// No dependencies; imported by dflr_scan and the top level.

package dflr_pkg;

   // character codes the scanner looks for
   localparam logic [7:0] CH_DIGIT_LO = 8'h30;  // '0'
   localparam logic [7:0] CH_DIGIT_HI = 8'h39;  // '9'
   localparam logic [7:0] CH_PLUS     = 8'h2B;  // '+'
   localparam logic [7:0] CH_MINUS    = 8'h2D;  // '-'
   localparam logic [7:0] CH_DOT      = 8'h2E;  // '.'
   localparam logic [7:0] CH_EXP_LO   = 8'h65;  // 'e'
   localparam logic [7:0] CH_EXP_HI   = 8'h45;  // 'E'

   localparam int          LEN_W   = 8;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   // outcome of the current beat, from the scanner to the top level
   typedef struct packed {
      logic             emit;    // this beat closes the token with a result
      logic             found;   // a number prefix was recognized
      logic [LEN_W-1:0] length;  // characters in the number, zero when not found
   } scan_result_type;

endpackage

[design/dflr_scan.sv]
`timescale 1ns / 1ps
// Scanner state machine: classifies one character, moves the eight-state machine
// and keeps the saturating length count. Depends on dflr_pkg.

module dflr_scan (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,    // held beat is consumed this cycle
   input  logic [7:0]               ch,
   input  logic                     first,
   output dflr_pkg::scan_result_type result
);
   import dflr_pkg::*;

   typedef enum logic [2:0] {
      ST_START   = 3'd0,
      ST_SIGN    = 3'd1,
      ST_INT     = 3'd2,
      ST_DOT     = 3'd3,
      ST_FRAC    = 3'd4,
      ST_EXP     = 3'd5,
      ST_EXPSIGN = 3'd6,
      ST_EXPDIG  = 3'd7
   } state_type;

   typedef enum logic [1:0] {
      MV_ACCEPT = 2'd0,
      MV_END    = 2'd1,
      MV_REJECT = 2'd2
   } move_type;

   state_type        state_ff, state_in, cur_state, next_state;
   logic [LEN_W-1:0] count_ff, count_in, cur_count;
   logic             done_ff, done_in;
   logic             active;
   logic             is_dig, is_sgn, is_exp, is_dot;
   move_type         move;

   // character classes
   always_comb begin
      is_dig = ch inside {[CH_DIGIT_LO:CH_DIGIT_HI]};
      is_sgn = (ch == CH_PLUS) || (ch == CH_MINUS);
      is_exp = (ch == CH_EXP_LO) || (ch == CH_EXP_HI);
      is_dot = (ch == CH_DOT);
   end

   // a first beat restarts the machine on itself
   assign cur_state = first ? ST_START : state_ff;
   assign cur_count = first ? '0 : count_ff;
   assign active    = first || !done_ff;

   // transition decode
   always_comb begin
      next_state = cur_state;
      move       = MV_REJECT;
      case (cur_state)
         ST_START: begin
            if (is_sgn) begin
               next_state = ST_SIGN; move = MV_ACCEPT;
            end else if (is_dig) begin
               next_state = ST_INT; move = MV_ACCEPT;
            end else if (is_dot) begin
               next_state = ST_DOT; move = MV_ACCEPT;
            end
         end
         ST_SIGN: begin
            if (is_dot) begin
               next_state = ST_DOT; move = MV_ACCEPT;
            end else if (is_dig) begin
               next_state = ST_INT; move = MV_ACCEPT;
            end
         end
         ST_INT: begin
            move = MV_END;
            if (is_exp) begin
               next_state = ST_EXP; move = MV_ACCEPT;
            end else if (is_dig) begin
               next_state = ST_INT; move = MV_ACCEPT;
            end else if (is_dot) begin
               next_state = ST_FRAC; move = MV_ACCEPT;
            end
         end
         ST_DOT: begin
            if (is_dig) begin
               next_state = ST_FRAC; move = MV_ACCEPT;
            end
         end
         ST_FRAC: begin
            move = MV_END;
            if (is_exp) begin
               next_state = ST_EXP; move = MV_ACCEPT;
            end else if (is_dig) begin
               next_state = ST_FRAC; move = MV_ACCEPT;
            end
         end
         ST_EXP: begin
            if (is_sgn) begin
               next_state = ST_EXPSIGN; move = MV_ACCEPT;
            end else if (is_dig) begin
               next_state = ST_EXPDIG; move = MV_ACCEPT;
            end
         end
         ST_EXPSIGN: begin
            if (is_dig) begin
               next_state = ST_EXPDIG; move = MV_ACCEPT;
            end
         end
         ST_EXPDIG: begin
            move = MV_END;
            if (is_dig) begin
               next_state = ST_EXPDIG; move = MV_ACCEPT;
            end
         end
         default: begin
            next_state = ST_START;
            move       = MV_REJECT;
         end
      endcase
   end

   // result of this beat
   always_comb begin
      result.emit   = active && (move != MV_ACCEPT);
      result.found  = (move == MV_END);
      result.length = (move == MV_END) ? cur_count : '0;
   end

   // next state of the token
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      done_in  = done_ff;
      if (step && active) begin
         state_in = next_state;
         count_in = cur_count;
         done_in  = (move != MV_ACCEPT);
         if (move == MV_ACCEPT && cur_count != LEN_MAX) begin
            count_in = cur_count + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         count_ff <= '0;
         done_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

endmodule

[design/decimal_float_literal_recognizer.sv]
`timescale 1ns / 1ps
// Top level of the decimal float literal recognizer: input register, scanner,
// result register. Depends on dflr_pkg and dflr_scan.
//
//  channel  dir  tdata            tuser   beat
//  req      in   [7:0] ch         first   one character
//  rsp      out  [7:0] length     found   at most one result per token
//
// One character per cycle while no closing beat waits on a stalled result.
// A beat waits in the input register; scanner decode feeds the result register.
// Reset clears the scanner to its start state, waiting for a first beat.
// A stalled result holds the input register only for a beat that closes a token;
// beats that give no result keep flowing through the scanner.

module decimal_float_literal_recognizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] ch
   input  logic       req_tuser,   // [0] first
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] length
   output logic       rsp_tuser    // [0] found
);
   import dflr_pkg::*;

   logic             in_vld_ff, in_vld_in;
   logic [7:0]       in_ch_ff;
   logic             in_first_ff;
   logic             rsp_vld_ff, rsp_vld_in;
   logic [LEN_W-1:0] rsp_len_ff;
   logic             rsp_found_ff;
   logic             out_free, step, req_fire;
   scan_result_type  res;

   // handshake
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign step       = in_vld_ff && (!res.emit || out_free);
   assign req_tready = !in_vld_ff || step;
   assign req_fire   = req_tvalid && req_tready;

   dflr_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .ch     (in_ch_ff),
      .first  (in_first_ff),
      .result (res)
   );

   // input register
   assign in_vld_in = req_fire || (in_vld_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      if (req_fire) begin
         in_ch_ff    <= req_tdata;
         in_first_ff <= req_tuser;
      end
   end

   // result register
   assign rsp_vld_in = (step && res.emit) || (rsp_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      if (step && res.emit) begin
         rsp_len_ff   <= res.length;
         rsp_found_ff <= res.found;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_len_ff;
   assign rsp_tuser  = rsp_found_ff;

`ifndef SYNTHESIS
   // a rejected token never carries a length
   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_found_ff |-> rsp_len_ff == '0)
      else $error("result without a number carries a nonzero length");

   // the input side only stalls behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_vld_ff && !rsp_tready && res.emit)
      else $error("input stalled without output backpressure");

   // nothing is presented right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_vld_ff && !in_vld_ff)
      else $error("beat held across reset");
`endif

endmodule
